// ===== rtl/core/sdr_pkg.sv =====
// Shared types and constants for the SHiP/DIP/RRIP replacement block.
package sdr_pkg;

   localparam int SET_MAX_W = 16;
   localparam int SIG_MAX_W = 16;
   localparam int PSEL_W    = 10;

   localparam logic [1:0]        RRPV_MAX  = 2'd3;
   localparam logic [1:0]        INS_NEAR  = 2'd0;
   localparam logic [1:0]        INS_DIST  = 2'd2;
   localparam logic [PSEL_W-1:0] PSEL_MID  = 10'd512;
   localparam logic [PSEL_W-1:0] PSEL_MAX  = 10'd1023;
   localparam logic [PSEL_W-1:0] PSEL_MIN  = 10'd0;

   localparam logic KIND_FIND   = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [SET_MAX_W-1:0] set_idx;
      logic [3:0]           way;
      logic                 way_ok;
      logic [SIG_MAX_W-1:0] sig;
      logic                 hit;
      logic [4:0]           rnd;
      logic                 near_leader;
      logic                 bim_leader;
   } op_type;

endpackage

// ===== rtl/core/sdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sdr_front.sv =====
// Request intake: decodes set, signature and dueling role into a two-entry queue.
module sdr_front import sdr_pkg::*; #(
   parameter int SETS        = 2048,
   parameter int WAYS        = 16,
   parameter int SIG_ENTRIES = 4096,
   parameter int LEADER_SETS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   output logic         op_valid,
   output op_type       op_head,
   input  logic         op_pop
);

   localparam int SET_W = $clog2(SETS);
   localparam int SIG_W = $clog2(SIG_ENTRIES);

   op_type               q_ff [2];
   op_type               q_in;
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 push;
   logic [SET_W+10:0]    set_ext;
   logic [SET_W-1:0]     set_w;
   logic [3:0]           way_f;

   assign req_tready = cnt_ff != 2'd2;
   assign push       = req_tvalid && req_tready;
   assign op_valid   = cnt_ff != 2'd0;
   assign op_head    = q_ff[rd_ptr_ff];

   always_comb begin
      set_ext            = (SET_W+11)'(req_tdata[10:0]);
      set_w              = set_ext[SET_W-1:0];
      way_f              = req_tdata[14:11];
      q_in.kind          = req_tuser[0];
      q_in.set_idx       = SET_MAX_W'(set_w);
      q_in.way           = way_f;
      q_in.way_ok        = (WAYS >= 16) || ({1'b0, way_f} < 5'(WAYS));
      q_in.sig           = SIG_MAX_W'(req_tdata[15+SIG_W+1:15+2]);
      q_in.hit           = req_tuser[1];
      q_in.rnd           = req_tdata[83:79];
      q_in.near_leader   = {1'b0, set_w} < (SET_W+1)'(LEADER_SETS);
      q_in.bim_leader    = !q_in.near_leader &&
                           ({1'b0, set_w} >= (SET_W+1)'(SETS - LEADER_SETS));
      wr_ptr_in          = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in          = op_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in             = cnt_ff + {1'b0, push} - {1'b0, op_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      op_pop |-> op_valid) else $error("pop from empty queue");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !op_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count did not advance");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue overfilled");

endmodule

// ===== rtl/core/sdr_engine.sv =====
// Execution engine: row memories, reuse counters, victim scan, aging and fills.
module sdr_engine import sdr_pkg::*; #(
   parameter int SETS        = 2048,
   parameter int WAYS        = 16,
   parameter int SIG_ENTRIES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         op_valid,
   input  op_type       op_head,
   output logic         op_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata
);

   localparam int SET_W = $clog2(SETS);
   localparam int SIG_W = $clog2(SIG_ENTRIES);
   localparam int WAY_W = $clog2(WAYS);
   localparam int CLR_N = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
   localparam int CLR_W = $clog2(CLR_N);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ROW, S_SCAN_A, S_SCAN_C, S_AGE, S_HIT, S_HIT_W,
      S_OLD_RD, S_OLD_W, S_NEW_RD, S_NEW_W, S_RESP
   } state_type;

   state_type                      state_ff, state_in;
   op_type                         op_ff;
   logic [CLR_W-1:0]               clr_ff;
   logic [WAY_W-1:0]               w_ff;
   logic [WAY_W-1:0]               victim_ff, victim_in;
   logic [PSEL_W-1:0]              psel_ff, psel_in;
   logic                           rsp_valid_ff;
   logic [15:0]                    rsp_data_ff;
   logic [WAYS-1:0][1:0]           rrpv_row_ff;
   logic [WAYS-1:0][SIG_W-1:0]     sig_row_ff;
   logic [SIG_W-1:0]               cnt_addr_ff, cnt_addr_in;

   logic [SET_W-1:0]               row_rd_addr, row_wr_addr;
   logic                           rrpv_we, sig_we, cnt_we;
   logic [WAYS-1:0][1:0]           rrpv_wd, rrpv_rd, aged;
   logic [WAYS-1:0][SIG_W-1:0]     sig_wd, sig_rd;
   logic [SIG_W-1:0]               cnt_wr_addr;
   logic [1:0]                     cnt_wd, cnt_rd, top, ins;
   logic [WAY_W-1:0]               op_way;
   logic [WAY_W+3:0]               victim_ext;
   logic                           any3, any2, any1, bim_near;

   sdr_ram #(.WIDTH(WAYS*2), .DEPTH(SETS)) u_rrpv (
      .clock(clock), .wr_en(rrpv_we), .wr_addr(row_wr_addr), .wr_data(rrpv_wd),
      .rd_addr(row_rd_addr), .rd_data(rrpv_rd));

   sdr_ram #(.WIDTH(WAYS*SIG_W), .DEPTH(SETS)) u_sig (
      .clock(clock), .wr_en(sig_we), .wr_addr(row_wr_addr), .wr_data(sig_wd),
      .rd_addr(row_rd_addr), .rd_data(sig_rd));

   sdr_ram #(.WIDTH(2), .DEPTH(SIG_ENTRIES)) u_cnt (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_wr_addr), .wr_data(cnt_wd),
      .rd_addr(cnt_addr_in), .rd_data(cnt_rd));

   assign op_way     = WAY_W'(op_ff.way);
   assign victim_ext = (WAY_W+4)'(victim_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         any3 |= rrpv_row_ff[i] == 2'd3;
         any2 |= rrpv_row_ff[i] == 2'd2;
         any1 |= rrpv_row_ff[i] == 2'd1;
      end
      top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
      for (int i = 0; i < WAYS; i++) begin
         aged[i] = rrpv_row_ff[i] + (RRPV_MAX - top);
      end
   end

   always_comb begin
      bim_near = op_ff.rnd == 5'd0;
      priority if (op_ff.near_leader) begin
         ins = INS_NEAR;
      end else if (op_ff.bim_leader) begin
         ins = bim_near ? INS_NEAR : INS_DIST;
      end else if (psel_ff >= PSEL_MID) begin
         ins = INS_NEAR;
      end else begin
         ins = bim_near ? INS_NEAR : INS_DIST;
      end
      if (cnt_rd <= 2'd1) begin
         ins = INS_DIST;
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_pop      = 1'b0;
      victim_in   = victim_ff;
      psel_in     = psel_ff;
      row_rd_addr = op_head.set_idx[SET_W-1:0];
      row_wr_addr = op_ff.set_idx[SET_W-1:0];
      rrpv_we     = 1'b0;
      sig_we      = 1'b0;
      cnt_we      = 1'b0;
      rrpv_wd     = rrpv_row_ff;
      sig_wd      = sig_row_ff;
      cnt_wr_addr = cnt_addr_ff;
      cnt_wd      = cnt_rd;
      cnt_addr_in = cnt_addr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            row_wr_addr = clr_ff[SET_W-1:0];
            rrpv_we     = {1'b0, clr_ff} < (CLR_W+1)'(SETS);
            sig_we      = rrpv_we;
            for (int i = 0; i < WAYS; i++) begin
               rrpv_wd[i] = RRPV_MAX;
               sig_wd[i]  = '0;
            end
            cnt_we      = {1'b0, clr_ff} < (CLR_W+1)'(SIG_ENTRIES);
            cnt_wr_addr = clr_ff[SIG_W-1:0];
            cnt_wd      = 2'd0;
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            victim_in = '0;
            if (op_valid) begin
               op_pop   = 1'b1;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            if (op_ff.kind == KIND_FIND) begin
               state_in = S_SCAN_A;
            end else if (!op_ff.way_ok) begin
               state_in = S_RESP;
            end else if (op_ff.hit) begin
               state_in = S_HIT;
            end else begin
               state_in = S_OLD_RD;
            end
         end
         S_SCAN_A: begin
            cnt_addr_in = sig_row_ff[w_ff];
            state_in    = S_SCAN_C;
         end
         S_SCAN_C: begin
            if (cnt_rd == 2'd0) begin
               victim_in = w_ff;
               state_in  = S_RESP;
            end else if (w_ff == WAY_W'(WAYS - 1)) begin
               state_in = S_AGE;
            end else begin
               state_in = S_SCAN_A;
            end
         end
         S_AGE: begin
            rrpv_we = 1'b1;
            rrpv_wd = aged;
            for (int i = WAYS - 1; i >= 0; i--) begin
               if (aged[i] == RRPV_MAX) begin
                  victim_in = WAY_W'(i);
               end
            end
            state_in = S_RESP;
         end
         S_HIT: begin
            rrpv_we         = 1'b1;
            rrpv_wd[op_way] = 2'd0;
            cnt_addr_in     = op_ff.sig[SIG_W-1:0];
            state_in        = S_HIT_W;
         end
         S_HIT_W: begin
            cnt_we   = 1'b1;
            cnt_wd   = (cnt_rd == RRPV_MAX) ? cnt_rd : cnt_rd + 2'd1;
            state_in = S_RESP;
         end
         S_OLD_RD: begin
            cnt_addr_in = sig_row_ff[op_way];
            state_in    = S_OLD_W;
         end
         S_OLD_W: begin
            cnt_we   = 1'b1;
            cnt_wd   = (cnt_rd == 2'd0) ? cnt_rd : cnt_rd - 2'd1;
            state_in = S_NEW_RD;
         end
         S_NEW_RD: begin
            cnt_addr_in = op_ff.sig[SIG_W-1:0];
            state_in    = S_NEW_W;
         end
         S_NEW_W: begin
            rrpv_we         = 1'b1;
            sig_we          = 1'b1;
            rrpv_wd[op_way] = ins;
            sig_wd[op_way]  = op_ff.sig[SIG_W-1:0];
            if (op_ff.bim_leader && psel_ff != PSEL_MIN) begin
               psel_in = psel_ff - 10'd1;
            end else if (op_ff.near_leader && psel_ff != PSEL_MAX) begin
               psel_in = psel_ff + 10'd1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         psel_ff      <= PSEL_MID;
         rsp_valid_ff <= 1'b0;
         w_ff         <= '0;
      end else begin
         state_ff <= state_in;
         psel_ff  <= psel_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + CLR_W'(1);
         end
         if (state_ff == S_ROW) begin
            w_ff <= '0;
         end else if (state_ff == S_SCAN_C) begin
            w_ff <= w_ff + WAY_W'(1);
         end
         if (state_ff == S_RESP && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      victim_ff   <= victim_in;
      cnt_addr_ff <= cnt_addr_in;
      if (op_pop) begin
         op_ff <= op_head;
      end
      if (state_ff == S_ROW) begin
         rrpv_row_ff <= rrpv_rd;
         sig_row_ff  <= sig_rd;
      end
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {2'b00, psel_ff, victim_ext[3:0]};
      end
   end

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !op_pop) else $error("request taken during clear");
   a_row_after_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROW |-> $past(state_ff) == S_IDLE) else $error("row read out of order");
   a_psel_only_fill: assert property (@(posedge clock) disable iff (reset)
      !$stable(psel_ff) && !$past(reset) |-> $past(state_ff) == S_NEW_W)
      else $error("selector moved outside a fill");

endmodule

// ===== rtl/core/ship_dip_rrip_replacement.sv =====
// Top level of the SHiP-lite / DIP / 2-bit RRIP last-level cache replacement policy.
// Usage:
//   req_* : one request per transfer. req_tuser = {was_hit, kind}; kind 0 asks
//           for a victim in set_index, kind 1 updates way_index after an access.
//   rsp_* : exactly one result per request, in order: victim_way (0 for
//           updates) and the policy selector after the request.
// Victim search: the reuse-counter memory has one read port and is read once
//   per way scanned.
// Throughput: one request in the engine at a time; a two-entry queue keeps
//   accepting while the engine works or the result waits.
// Reset: synchronous. Afterwards a clearing pass over max(SETS, SIG_ENTRIES)
//   addresses presets all rows and counters; requests queue
//   up but are not executed until it ends.
// Stall: the result stays in the output register until rsp_tready; the
//   engine holds its next result, and req_tready drops once the queue is full.
module ship_dip_rrip_replacement import sdr_pkg::*; #(
   parameter int SETS        = 2048,
   parameter int WAYS        = 16,
   parameter int SIG_ENTRIES = 4096,
   parameter int LEADER_SETS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,  // set_index, way_index, access_pc, random_bits
   input  logic [1:0]   req_tuser,  // kind, was_hit
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata   // victim_way, psel_level
);

   logic   op_valid;
   logic   op_pop;
   op_type op_head;

   sdr_front #(
      .SETS(SETS), .WAYS(WAYS), .SIG_ENTRIES(SIG_ENTRIES), .LEADER_SETS(LEADER_SETS)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .op_valid(op_valid), .op_head(op_head), .op_pop(op_pop));

   sdr_engine #(
      .SETS(SETS), .WAYS(WAYS), .SIG_ENTRIES(SIG_ENTRIES)
   ) u_engine (
      .clock(clock), .reset(reset),
      .op_valid(op_valid), .op_head(op_head), .op_pop(op_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

endmodule
